>>> rtl/lqi_pkg.sv
// Shared constants and types of the line versus quadric intersection unit.
// No dependencies; the top module and lqi_mul import it.
package lqi_pkg;

    localparam int OUT_W      = 48;   // Q31.16 point coordinate
    localparam int QUO_BITS   = 49;   // quotient bits kept before saturation
    localparam int K_SHIFT    = 16;   // coefficient scale 2^16
    localparam int LIMB_W     = 32;   // partial product limb width
    localparam int CFG_DATA_W = 32;   // widest register
    localparam int USER_W     = 8;

    localparam logic [1:0] KIND_SPHERE   = 2'd0;
    localparam logic [1:0] KIND_CYLINDER = 2'd1;
    localparam logic [1:0] KIND_CONE     = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    localparam logic [1:0] REG_KIND   = 2'd0;
    localparam logic [1:0] REG_RADIUS = 2'd1;
    localparam logic [1:0] REG_CONE_K = 2'd2;

    localparam logic [1:0] HITS_NONE = 2'd0;
    localparam logic [1:0] HITS_ONE  = 2'd1;
    localparam logic [1:0] HITS_TWO  = 2'd2;

    typedef struct packed {
        logic degen;
        logic no_hit;
        logic tangent;
    } lqi_flags_t;

endpackage

>>> rtl/line_quadric_intersection_unit.sv
// Line versus sphere, cylinder or cone intersection, fully pipelined.
// The pipeline holds a bit-per-stage square root and 49-stage quotient dividers.
// Throughput: one item per cycle while the output buffer is not full; a two-entry
// output buffer absorbs m_tready stalls, and the whole pipe halts while it is full.
// Reset (aresetn low, synchronous): registers return to sphere, radius 1,
// cone slope 1.0; valid bits and the output buffer clear. Depends on lqi_pkg.
module line_quadric_intersection_unit #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [1:0]                              cfg_index,
    input  logic [lqi_pkg::CFG_DATA_W-1:0]          cfg_wdata,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // point_x, point_y, point_z, dir_x, dir_y, dir_z, zero fill
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]       s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // near_x, near_y, near_z, far_x, far_y, far_z
    output logic [6*lqi_pkg::OUT_W-1:0]             m_tdata,
    // hit_count[1:0], degenerate[2], zero fill
    output logic [lqi_pkg::USER_W-1:0]              m_tuser
);
    import lqi_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int FB  = FRAC_BITS;
    localparam int ZW  = 2 * CB;
    localparam int WC  = 2 * CB + 34;
    localparam int WS  = WC;
    localparam int WN  = WC + 2;
    localparam int WP  = CB + WN;
    localparam int WM  = WP + FB;
    localparam int WX  = WM + 1;
    localparam int CW  = ((WX > WC + QUO_BITS) ? WX : WC + QUO_BITS) + 1;
    localparam int FW  = QUO_BITS + 3;
    localparam int VD  = 15 + WS + QUO_BITS;
    localparam int PDW = 6 * CB;
    localparam int FLW = $bits(lqi_flags_t);
    localparam int ENT_W = USER_W + 6 * OUT_W;
    localparam logic signed [FW-1:0] SAT_HI = FW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [FW-1:0] SAT_LO = -SAT_HI - FW'(1);

    // configuration registers
    logic [1:0]            kind_reg;
    logic [14:0]           radius_reg;
    logic [CFG_DATA_W-1:0] cone_k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg   <= KIND_SPHERE;
            radius_reg <= 15'd1;
            cone_k_reg <= 32'd65536;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_KIND:   kind_reg   <= cfg_wdata[1:0];
                REG_RADIUS: radius_reg <= cfg_wdata[14:0];
                REG_CONE_K: cone_k_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic       ce;
    logic [1:0] fifo_cnt_reg;
    logic       push;
    logic       pop;
    logic [VD-1:0] vld_reg;

    // the whole pipe advances unless the output buffer is full
    assign ce       = (fifo_cnt_reg != 2'd2);
    assign s_tready = ce & aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[VD-2:0], s_tvalid};
        end
    end

    // stage 1: elementary products
    logic signed [CB-1:0] pt [3];
    logic signed [CB-1:0] dr [3];
    logic signed [ZW-1:0] s1_dd_reg [3];
    logic signed [ZW-1:0] s1_dp_reg [3];
    logic signed [ZW-1:0] s1_pp_reg [3];
    logic [29:0]          s1_r2_reg;
    logic [PDW-1:0]       s1_pd_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pt[i] = s_tdata[i*CB +: CB];
            dr[i] = s_tdata[(3+i)*CB +: CB];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                s1_dd_reg[i] <= dr[i] * dr[i];
                s1_dp_reg[i] <= dr[i] * pt[i];
                s1_pp_reg[i] <= pt[i] * pt[i];
            end
            s1_r2_reg <= radius_reg * radius_reg;
            s1_pd_reg <= s_tdata[PDW-1:0];
        end
    end

    // stage 2: xy sums, the full sphere or cylinder coefficients and the cone's xy parts
    logic signed [WC-1:0] axy, hxy, cxy, zdd, zdp, zpp, r2w;
    logic signed [WC-1:0] a2_next, h2_next, c2_next;
    logic signed [WC-1:0] s2_a_reg, s2_h_reg, s2_c_reg;
    logic signed [ZW-1:0] s2_z_reg [3];

    assign axy = WC'(s1_dd_reg[0]) + WC'(s1_dd_reg[1]);
    assign hxy = WC'(s1_dp_reg[0]) + WC'(s1_dp_reg[1]);
    assign cxy = WC'(s1_pp_reg[0]) + WC'(s1_pp_reg[1]);
    assign zdd = WC'(s1_dd_reg[2]);
    assign zdp = WC'(s1_dp_reg[2]);
    assign zpp = WC'(s1_pp_reg[2]);
    assign r2w = $signed(WC'(s1_r2_reg));

    always_comb begin
        case (kind_reg)
            KIND_SPHERE: begin
                a2_next = (axy + zdd) <<< K_SHIFT;
                h2_next = (hxy + zdp) <<< K_SHIFT;
                c2_next = (cxy + zpp - r2w) <<< K_SHIFT;
            end
            KIND_CYLINDER: begin
                a2_next = axy <<< K_SHIFT;
                h2_next = hxy <<< K_SHIFT;
                c2_next = (cxy - r2w) <<< K_SHIFT;
            end
            KIND_CONE: begin
                a2_next = axy <<< K_SHIFT;
                h2_next = hxy <<< K_SHIFT;
                c2_next = cxy <<< K_SHIFT;
            end
            default: begin
                a2_next = '0;
                h2_next = '0;
                c2_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s2_a_reg    <= a2_next;
            s2_h_reg    <= h2_next;
            s2_c_reg    <= c2_next;
            s2_z_reg[0] <= s1_dd_reg[2];
            s2_z_reg[1] <= s1_dp_reg[2];
            s2_z_reg[2] <= s1_pp_reg[2];
        end
    end

    // stages 3-5: cone slope times the z terms
    logic signed [ZW+32:0] kz [3];
    logic [3*WC-1:0]       ahc5;

    for (genvar g = 0; g < 3; g++) begin : g_kmul
        lqi_mul #(.WA(ZW), .WB(33)) u_kmul (
            .aclk (aclk),
            .ce   (ce),
            .a    (s2_z_reg[g]),
            .b    ($signed({1'b0, cone_k_reg})),
            .p    (kz[g])
        );
    end

    lqi_delay #(.W(3*WC), .D(3)) u_dly_ahc (
        .aclk (aclk),
        .ce   (ce),
        .din  ({s2_a_reg, s2_h_reg, s2_c_reg}),
        .dout (ahc5)
    );

    // stage 6: final coefficients
    logic signed [WC-1:0] s5_a_reg, s5_h_reg, s5_c_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (kind_reg == KIND_CONE) begin
                s5_a_reg <= $signed(ahc5[3*WC-1 -: WC]) - WC'(kz[0]);
                s5_h_reg <= $signed(ahc5[2*WC-1 -: WC]) - WC'(kz[1]);
                s5_c_reg <= $signed(ahc5[WC-1:0]) - WC'(kz[2]);
            end else begin
                s5_a_reg <= $signed(ahc5[3*WC-1 -: WC]);
                s5_h_reg <= $signed(ahc5[2*WC-1 -: WC]);
                s5_c_reg <= $signed(ahc5[WC-1:0]);
            end
        end
    end

    // stages 7-10: quarter discriminant h*h - a*c
    logic signed [2*WC-1:0] hh, ac;
    logic signed [2*WC:0]   s8_disc_reg;
    logic [2*WC-1:0]        ah10;

    lqi_mul #(.WA(WC), .WB(WC)) u_hh (
        .aclk (aclk), .ce (ce), .a (s5_h_reg), .b (s5_h_reg), .p (hh)
    );

    lqi_mul #(.WA(WC), .WB(WC)) u_ac (
        .aclk (aclk), .ce (ce), .a (s5_a_reg), .b (s5_c_reg), .p (ac)
    );

    lqi_delay #(.W(2*WC), .D(4)) u_dly_ah10 (
        .aclk (aclk), .ce (ce), .din ({s5_a_reg, s5_h_reg}), .dout (ah10)
    );

    always_ff @(posedge aclk) begin
        if (ce) begin
            s8_disc_reg <= (2*WC+1)'(hh) - (2*WC+1)'(ac);
        end
    end

    lqi_flags_t fl10;
    lqi_flags_t fl_out;
    logic [FLW-1:0] fl_out_bits;

    assign fl10.degen   = (ah10[2*WC-1 -: WC] == '0) ||
                          ((kind_reg != KIND_SPHERE) && (kind_reg != KIND_CYLINDER) &&
                           (kind_reg != KIND_CONE));
    assign fl10.no_hit  = s8_disc_reg[2*WC];
    assign fl10.tangent = (s8_disc_reg == '0);

    lqi_delay #(.W(FLW), .D(VD - 10)) u_dly_flags (
        .aclk (aclk), .ce (ce), .din (fl10), .dout (fl_out_bits)
    );
    assign fl_out = lqi_flags_t'(fl_out_bits);

    // square root of the discriminant
    logic [WS-1:0]   root;
    logic [2*WC-1:0] ah_sq;
    logic [PDW-1:0]  pd_sq;

    lqi_sqrt #(.WS(WS)) u_sqrt (
        .aclk (aclk), .ce (ce), .v (s8_disc_reg[2*WC-1:0]), .root (root)
    );

    lqi_delay #(.W(2*WC), .D(WS)) u_dly_ah_sq (
        .aclk (aclk), .ce (ce), .din (ah10), .dout (ah_sq)
    );

    lqi_delay #(.W(PDW), .D(9 + WS)) u_dly_pd (
        .aclk (aclk), .ce (ce), .din (s1_pd_reg), .dout (pd_sq)
    );

    // numerators: near takes the smaller t, which flips with the sign of a
    logic signed [WC-1:0] a_sq;
    logic signed [WN-1:0] mh, sq;
    logic signed [WN-1:0] sn_n_reg [2];
    logic signed [WC-1:0] sn_a_reg;
    logic [PDW-1:0]       sn_pd_reg;

    assign a_sq = $signed(ah_sq[2*WC-1 -: WC]);
    assign mh   = -WN'($signed(ah_sq[WC-1:0]));
    assign sq   = $signed(WN'(root));

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (a_sq[WC-1]) begin
                sn_n_reg[0] <= mh + sq;
                sn_n_reg[1] <= mh - sq;
            end else begin
                sn_n_reg[0] <= mh - sq;
                sn_n_reg[1] <= mh + sq;
            end
            sn_a_reg  <= a_sq;
            sn_pd_reg <= pd_sq;
        end
    end

    // direction times numerator, coordinate k = 3*far + axis
    logic signed [WP-1:0] dn [6];
    logic signed [WC-1:0] a14;
    logic [3*CB-1:0]      p_out;

    for (genvar g = 0; g < 6; g++) begin : g_dnmul
        lqi_mul #(.WA(CB), .WB(WN)) u_dnmul (
            .aclk (aclk),
            .ce   (ce),
            .a    ($signed(sn_pd_reg[(3 + g % 3)*CB +: CB])),
            .b    (sn_n_reg[g / 3]),
            .p    (dn[g])
        );
    end

    lqi_delay #(.W(WC), .D(3)) u_dly_a14 (
        .aclk (aclk), .ce (ce), .din (sn_a_reg), .dout (a14)
    );

    lqi_delay #(.W(3*CB), .D(4 + QUO_BITS)) u_dly_p (
        .aclk (aclk), .ce (ce), .din (sn_pd_reg[3*CB-1:0]), .dout (p_out)
    );

    // dividend with half-divisor rounding, sign and overflow screen
    logic [WC-1:0]  abs_a;
    logic [WX-1:0]  x_next [6];
    logic [11:0]    sgn_next;
    logic [WX-1:0]  sx_x_reg [6];
    logic [WC-1:0]  sx_a_reg;
    logic [11:0]    sx_sgn_reg;
    logic [11:0]    sgn_out;

    assign abs_a = a14[WC-1] ? WC'(-a14) : WC'(a14);

    always_comb begin
        logic signed [WM-1:0] num;
        logic [WM-1:0]        mag;
        for (int k = 0; k < 6; k++) begin
            num = WM'(dn[k]) <<< FB;
            mag = num[WM-1] ? WM'(-num) : WM'(num);
            x_next[k] = WX'(mag) + WX'(abs_a >> 1);
            sgn_next[k] = num[WM-1] ^ a14[WC-1];
            sgn_next[6+k] = (CW'(x_next[k]) >= (CW'(abs_a) << QUO_BITS));
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sx_x_reg   <= x_next;
            sx_a_reg   <= abs_a;
            sx_sgn_reg <= sgn_next;
        end
    end

    lqi_delay #(.W(12), .D(QUO_BITS)) u_dly_sgn (
        .aclk (aclk), .ce (ce), .din (sx_sgn_reg), .dout (sgn_out)
    );

    logic [QUO_BITS-1:0] quo [6];

    for (genvar g = 0; g < 6; g++) begin : g_div
        lqi_div #(.WX(WX), .WA(WC), .QB(QUO_BITS)) u_div (
            .aclk (aclk), .ce (ce), .x (sx_x_reg[g]), .a (sx_a_reg), .q (quo[g])
        );
    end

    // add the point, saturate, and apply the special cases
    logic [OUT_W-1:0]  crd [6];
    logic [ENT_W-1:0]  entry;

    always_comb begin
        logic signed [FW-1:0] qv;
        logic signed [FW-1:0] pv;
        logic signed [FW-1:0] vv;
        for (int k = 0; k < 6; k++) begin
            qv = $signed(FW'(quo[k]));
            if (sgn_out[k]) begin
                qv = -qv;
            end
            pv = FW'($signed(p_out[(k % 3)*CB +: CB])) <<< FB;
            vv = qv + pv;
            if (sgn_out[6+k]) begin
                crd[k] = sgn_out[k] ? OUT_W'(SAT_LO) : OUT_W'(SAT_HI);
            end else if (vv > SAT_HI) begin
                crd[k] = OUT_W'(SAT_HI);
            end else if (vv < SAT_LO) begin
                crd[k] = OUT_W'(SAT_LO);
            end else begin
                crd[k] = OUT_W'(vv);
            end
        end
    end

    always_comb begin
        entry = '0;
        if (fl_out.degen) begin
            entry[6*OUT_W + 2] = 1'b1;
        end else if (fl_out.no_hit) begin
            entry[6*OUT_W +: 2] = HITS_NONE;
        end else if (fl_out.tangent) begin
            entry[6*OUT_W +: 2] = HITS_ONE;
            for (int k = 0; k < 3; k++) begin
                entry[k*OUT_W +: OUT_W] = crd[k];
            end
        end else begin
            entry[6*OUT_W +: 2] = HITS_TWO;
            for (int k = 0; k < 6; k++) begin
                entry[k*OUT_W +: OUT_W] = crd[k];
            end
        end
    end

    // two-entry output buffer
    logic [ENT_W-1:0] fifo_mem [2];
    logic             fifo_wr_reg;
    logic             fifo_rd_reg;

    assign push = ce & vld_reg[VD-1];
    assign pop  = (fifo_cnt_reg != 2'd0) & m_tready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[fifo_wr_reg] <= entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_cnt_reg <= 2'd0;
            fifo_wr_reg  <= 1'b0;
            fifo_rd_reg  <= 1'b0;
        end else begin
            if (push) begin
                fifo_wr_reg <= ~fifo_wr_reg;
            end
            if (pop) begin
                fifo_rd_reg <= ~fifo_rd_reg;
            end
            case ({push, pop})
                2'b10:   fifo_cnt_reg <= fifo_cnt_reg + 2'd1;
                2'b01:   fifo_cnt_reg <= fifo_cnt_reg - 2'd1;
                default: fifo_cnt_reg <= fifo_cnt_reg;
            endcase
        end
    end

    assign m_tvalid = (fifo_cnt_reg != 2'd0);
    assign m_tdata  = fifo_mem[fifo_rd_reg][6*OUT_W-1:0];
    assign m_tuser  = fifo_mem[fifo_rd_reg][ENT_W-1 -: USER_W];

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (fifo_cnt_reg == 2'd2) |-> !push)
        else $error("output buffer written while full");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_degen_no_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == HITS_NONE))
        else $error("degenerate item reports hits");

    a_tangent_far_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] == HITS_ONE)) |-> (m_tdata[6*OUT_W-1:3*OUT_W] == '0))
        else $error("tangent item has nonzero far point");

endmodule

>>> rtl/lqi_delay.sv
// Clock-enabled delay line for the payload that rides beside the arithmetic.
// No dependencies.
module lqi_delay #(
    parameter int W = 8,
    parameter int D = 2
) (
    input  logic         aclk,
    input  logic         ce,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] dly_reg [D];

    always_ff @(posedge aclk) begin
        if (ce) begin
            dly_reg[0] <= din;
            for (int i = 1; i < D; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign dout = dly_reg[D-1];

endmodule

>>> rtl/lqi_mul.sv
// Three-stage signed multiplier built from 32 by 32 limb products.
// Depends on lqi_pkg for the limb width.
module lqi_mul #(
    parameter int WA = 16,
    parameter int WB = 16
) (
    input  logic                    aclk,
    input  logic                    ce,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);
    import lqi_pkg::*;

    localparam int LA = (WA + LIMB_W - 1) / LIMB_W;
    localparam int LB = (WB + LIMB_W - 1) / LIMB_W;
    localparam int RW = (LB + 1) * LIMB_W;
    localparam int TW = (LA + LB) * LIMB_W;
    localparam int PW = WA + WB;

    logic [WA-1:0]          mag_a;
    logic [WB-1:0]          mag_b;
    logic [LA*LIMB_W-1:0]   ext_a;
    logic [LB*LIMB_W-1:0]   ext_b;
    logic [2*LIMB_W-1:0]    pp_reg [LA][LB];
    logic [RW-1:0]          row_reg [LA];
    logic [RW-1:0]          row_next [LA];
    logic [TW-1:0]          sum;
    logic [1:0]             neg_reg;
    logic signed [PW-1:0]   p_reg;
    logic signed [PW-1:0]   p_next;

    assign mag_a = a[WA-1] ? WA'(-a) : WA'(a);
    assign mag_b = b[WB-1] ? WB'(-b) : WB'(b);
    assign ext_a = (LA*LIMB_W)'(mag_a);
    assign ext_b = (LB*LIMB_W)'(mag_b);

    // row i collects limb a[i] times all of b
    always_comb begin
        for (int i = 0; i < LA; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < LB; j++) begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (LIMB_W * j));
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < LA; i++) begin
            sum = sum + (TW'(row_reg[i]) << (LIMB_W * i));
        end
        p_next = $signed(PW'(sum));
        if (neg_reg[1]) begin
            p_next = -p_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < LA; i++) begin
                for (int j = 0; j < LB; j++) begin
                    pp_reg[i][j] <= ext_a[i*LIMB_W +: LIMB_W] * ext_b[j*LIMB_W +: LIMB_W];
                end
            end
            neg_reg[0] <= a[WA-1] ^ b[WB-1];
            neg_reg[1] <= neg_reg[0];
            row_reg    <= row_next;
            p_reg      <= p_next;
        end
    end

    assign p = p_reg;

endmodule

>>> rtl/lqi_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// No dependencies; root is floor(sqrt(v)), taken from the last register stage.
module lqi_sqrt #(
    parameter int WS = 66
) (
    input  logic            aclk,
    input  logic            ce,
    input  logic [2*WS-1:0] v,
    output logic [WS-1:0]   root
);

    logic [WS:0]     rem_reg  [WS];
    logic [WS-1:0]   root_reg [WS];
    logic [2*WS-1:0] rad_reg  [WS];

    for (genvar g = 0; g < WS; g++) begin : g_stage
        logic [WS:0]     rem_in;
        logic [WS-1:0]   root_in;
        logic [2*WS-1:0] rad_in;
        logic [WS+2:0]   cur;
        logic [WS+2:0]   trial;
        logic            take;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = v;
        end else begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign rad_in  = rad_reg[g-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign cur   = {rem_in, rad_in[2*WS-1 -: 2]};
        assign trial = (WS+3)'({root_in, 2'b01});
        assign take  = (cur >= trial);

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[g]  <= take ? (WS+1)'(cur - trial) : (WS+1)'(cur);
                root_reg[g] <= {root_in[WS-2:0], take};
                rad_reg[g]  <= rad_in << 2;
            end
        end
    end

    assign root = root_reg[WS-1];

endmodule

>>> rtl/lqi_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// No dependencies; the caller guarantees x < a * 2^QB, else flags saturation.
module lqi_div #(
    parameter int WX = 101,
    parameter int WA = 66,
    parameter int QB = 49
) (
    input  logic          aclk,
    input  logic          ce,
    input  logic [WX-1:0] x,
    input  logic [WA-1:0] a,
    output logic [QB-1:0] q
);

    logic [WA-1:0] rem_reg [QB];
    logic [QB-1:0] low_reg [QB];
    logic [WA-1:0] dvs_reg [QB];
    logic [QB-1:0] quo_reg [QB];

    for (genvar g = 0; g < QB; g++) begin : g_stage
        logic [WA-1:0] rem_in;
        logic [QB-1:0] low_in;
        logic [WA-1:0] dvs_in;
        logic [QB-1:0] quo_in;
        logic [WA:0]   cur;
        logic          take;

        if (g == 0) begin : g_first
            assign rem_in = WA'(x >> QB);
            assign low_in = x[QB-1:0];
            assign dvs_in = a;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign low_in = low_reg[g-1];
            assign dvs_in = dvs_reg[g-1];
            assign quo_in = quo_reg[g-1];
        end

        assign cur  = {rem_in, low_in[QB-1]};
        assign take = (cur >= {1'b0, dvs_in});

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[g] <= take ? WA'(cur - {1'b0, dvs_in}) : WA'(cur);
                low_reg[g] <= low_in << 1;
                dvs_reg[g] <= dvs_in;
                quo_reg[g] <= {quo_in[QB-2:0], take};
            end
        end
    end

    assign q = quo_reg[QB-1];

endmodule
